// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising edge of clk, off while rst_n is low.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that an expression never holds on the rising edge of clk.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, !(expr), msg)

`endif

// File: sv/ffba_pkg.sv
// Types, codes and constants of the first-fit block allocator.
`default_nettype none

package ffba_pkg;

  localparam int SIZE_W   = 12;
  localparam int OFFSET_W = 11;
  localparam int STATUS_W = 2;

  localparam int POOL_BYTES   = 1024 * 2;
  localparam int HEADER_BYTES = 24;

  localparam logic [SIZE_W-1:0] HDR_SIZE = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] RST_SIZE = SIZE_W'(POOL_BYTES - HEADER_BYTES);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_OFFSET = 2'd2;

  // What the traveling request does at the cell it reaches.
  typedef enum logic [2:0] {
    MD_PASS,
    MD_ALLOC,
    MD_FREE,
    MD_INSERT,
    MD_SHIFT1,
    MD_SHIFT2
  } ffba_mode_e;

  // One table entry.
  typedef struct packed {
    logic              vld;
    logic              free;
    logic [SIZE_W-1:0] size;
  } ffba_ent_t;

  // Request beat as it travels from cell to cell.
  typedef struct packed {
    logic                act;
    ffba_mode_e          mode;
    logic [SIZE_W-1:0]   req;
    logic [OFFSET_W-1:0] rel;
    logic [OFFSET_W-1:0] st_lo;
    logic                st_big;
    ffba_ent_t           carry;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] offset;
  } ffba_tok_t;

  typedef struct packed {
    logic                op;
    logic [SIZE_W-1:0]   request_bytes;
    logic [OFFSET_W-1:0] release_offset;
  } ffba_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] payload_offset;
  } ffba_out_t;

endpackage

`default_nettype wire

// File: sv/ffba_cell.sv
// One table cell: holds one block entry and works on the request passing through.
`default_nettype none

module ffba_cell import ffba_pkg::*; #(
  parameter bit IS_HEAD = 1'b0
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ffba_tok_t tok_i,
  input  wire ffba_ent_t nb1_i,
  input  wire ffba_ent_t nb2_i,
  input  wire logic      full_i,
  output      ffba_tok_t tok_o,
  output      ffba_ent_t ent_o
);

  localparam ffba_ent_t RstEnt =
    IS_HEAD ? ffba_ent_t'{vld: 1'b1, free: 1'b1, size: RST_SIZE} : ffba_ent_t'('0);

  ffba_ent_t ent_q, ent_d;
  ffba_tok_t tok_q, tok_d;

  logic [12:0]         sum_nxt;
  logic                nxt_big;
  logic [SIZE_W-1:0]   pay_here;
  logic [SIZE_W-1:0]   pay_next;
  logic                hit_here;
  logic                hit_next;
  logic                fits;
  logic                splits;
  logic [SIZE_W-1:0]   merge1;
  logic [SIZE_W-1:0]   merge2;
  logic [SIZE_W-1:0]   remain;

  always_comb begin
    // Start of the next block; only the low bits and a sticky overflow are kept.
    sum_nxt  = 13'(tok_i.st_lo) + 13'(HDR_SIZE) + 13'(ent_q.size);
    nxt_big  = tok_i.st_big | (sum_nxt[12:11] != 2'b00);
    pay_here = SIZE_W'(tok_i.st_lo) + HDR_SIZE;
    pay_next = SIZE_W'(sum_nxt[10:0]) + HDR_SIZE;
    hit_here = ent_q.vld && !tok_i.st_big && (pay_here == SIZE_W'(tok_i.rel));
    hit_next = nb1_i.vld && !nxt_big && (pay_next == SIZE_W'(tok_i.rel));
    fits     = ent_q.vld && ent_q.free && (ent_q.size >= tok_i.req);
    splits   = 13'(ent_q.size) > (13'(tok_i.req) + 13'(HDR_SIZE));
    merge1   = ent_q.size + HDR_SIZE + nb1_i.size;
    merge2   = merge1 + HDR_SIZE + nb2_i.size;
    remain   = ent_q.size - HDR_SIZE - tok_i.req;

    ent_d        = ent_q;
    tok_d        = tok_i;
    tok_d.st_lo  = sum_nxt[10:0];
    tok_d.st_big = nxt_big;

    if (tok_i.act) begin
      case (tok_i.mode)
        MD_ALLOC: begin
          if (fits) begin
            ent_d.free   = 1'b0;
            tok_d.status = ST_OK;
            tok_d.offset = pay_here[OFFSET_W-1:0];
            tok_d.mode   = MD_PASS;
            if (splits && !full_i) begin
              ent_d.size  = tok_i.req;
              tok_d.carry = '{vld: 1'b1, free: 1'b1, size: remain};
              tok_d.mode  = MD_INSERT;
            end
          end
        end
        MD_FREE: begin
          if (hit_here) begin
            ent_d.free   = 1'b1;
            tok_d.status = ST_OK;
            tok_d.mode   = MD_PASS;
            if (nb1_i.vld && nb1_i.free) begin
              ent_d.size = merge1;
              tok_d.mode = MD_SHIFT1;
            end
          end else if (hit_next && ent_q.free) begin
            // Next block is the target and this one is free: absorb it here.
            tok_d.status = ST_OK;
            if (nb2_i.vld && nb2_i.free) begin
              ent_d.size = merge2;
              tok_d.mode = MD_SHIFT2;
            end else begin
              ent_d.size = merge1;
              tok_d.mode = MD_SHIFT1;
            end
          end
        end
        MD_INSERT: begin
          // Drop the carried entry here and carry the displaced one onward.
          ent_d       = tok_i.carry;
          tok_d.carry = ent_q;
          if (!ent_q.vld) begin
            tok_d.mode = MD_PASS;
          end
        end
        MD_SHIFT1: begin
          ent_d = nb1_i;
        end
        MD_SHIFT2: begin
          ent_d = nb2_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= RstEnt;
      tok_q <= '0;
    end else begin
      ent_q <= ent_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign ent_o = ent_q;

endmodule

`default_nettype wire

// File: sv/first_fit_block_allocator_unit.sv
// Top level of the first-fit block allocator: launch stage, cell chain, result stages.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i): one beat is one request,
//   op 0 allocates request_bytes, op 1 frees the block whose payload starts at
//   release_offset. Output channel (out_valid_o/out_ready_i/out_data_o): one
//   beat per request with status (0 ok, 1 no fitting free block, 2 offset is
//   not a block) and the payload offset of an allocation (zero otherwise).
//   The block table lives in a row of MAX_BLOCKS cells, one entry per cell.
//   A request travels down the row one cell per cycle, summing block starts,
//   picking the first fit, splitting or merging, and shifting the entries
//   behind it right or left as it goes.
//   A request passes the launch register, the cell row, the result register
//   and the output register. One request at a time: the next one is taken
//   only after the previous one has left the cell row.
//   The next request is taken while a finished result still waits at the
//   output; a stalled receiver holds the output beat and, once a second
//   result is ready behind it, in_ready_o stays low until the first is taken.
//   Reset: one free block of the whole pool minus one header, no beat pending.
`default_nettype none

module first_fit_block_allocator_unit import ffba_pkg::*; #(
  parameter int MAX_BLOCKS = 128
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire ffba_in_t  in_data_i,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      ffba_out_t out_data_o
);

  ffba_ent_t ent_w [MAX_BLOCKS];
  ffba_ent_t nb1_w [MAX_BLOCKS];
  ffba_ent_t nb2_w [MAX_BLOCKS];
  ffba_tok_t tok_w [MAX_BLOCKS+1];

  ffba_tok_t tok0_q, tok0_d;
  logic      busy_q, busy_d;
  ffba_out_t res_q, res_d;
  logic      res_vld_q, res_vld_d;
  ffba_out_t out_q, out_d;
  logic      out_vld_q, out_vld_d;

  logic      in_acc;
  logic      full;
  ffba_tok_t tok_last;

  assign in_ready_o = !busy_q && !res_vld_q;
  assign in_acc     = in_valid_i && in_ready_o;

  // Table full when the last cell holds a block.
  assign full     = ent_w[MAX_BLOCKS-1].vld;
  assign tok_last = tok_w[MAX_BLOCKS];
  assign tok_w[0] = tok0_q;

  genvar k;
  for (k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    if (k + 1 < MAX_BLOCKS) begin : g_nb1
      assign nb1_w[k] = ent_w[k+1];
    end else begin : g_nb1_end
      assign nb1_w[k] = '0;
    end
    if (k + 2 < MAX_BLOCKS) begin : g_nb2
      assign nb2_w[k] = ent_w[k+2];
    end else begin : g_nb2_end
      assign nb2_w[k] = '0;
    end

    ffba_cell #(
      .IS_HEAD(k == 0)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok_w[k]),
      .nb1_i (nb1_w[k]),
      .nb2_i (nb2_w[k]),
      .full_i(full),
      .tok_o (tok_w[k+1]),
      .ent_o (ent_w[k])
    );
  end

  always_comb begin
    // Launch: build the traveling beat from the accepted request.
    tok0_d        = '0;
    tok0_d.act    = in_acc;
    tok0_d.mode   = (in_data_i.op == OP_FREE) ? MD_FREE : MD_ALLOC;
    tok0_d.req    = in_data_i.request_bytes;
    tok0_d.rel    = in_data_i.release_offset;
    tok0_d.status = (in_data_i.op == OP_FREE) ? ST_BAD_OFFSET : ST_NO_FIT;

    busy_d    = busy_q;
    res_d     = res_q;
    res_vld_d = res_vld_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;

    // Advance the result into the output register when it is free or drains.
    if (res_vld_q && (!out_vld_q || out_ready_i)) begin
      out_d     = res_q;
      out_vld_d = 1'b1;
      res_vld_d = 1'b0;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end

    // Catch the beat leaving the last cell.
    if (tok_last.act) begin
      res_d.status         = tok_last.status;
      res_d.payload_offset = tok_last.offset;
      res_vld_d            = 1'b1;
      busy_d               = 1'b0;
    end

    if (in_acc) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok0_q    <= '0;
      busy_q    <= 1'b0;
      res_q     <= '0;
      res_vld_q <= 1'b0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      tok0_q    <= tok0_d;
      busy_q    <= busy_d;
      res_q     <= res_d;
      res_vld_q <= res_vld_d;
      out_q     <= out_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: sv/ffba_checker.sv
// Port-level checker for the first-fit block allocator, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module ffba_checker import ffba_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire ffba_in_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire ffba_out_t out_data_o
);

  logic out_stall;
  logic in_acc;
  logic fail_off;

  assign out_stall = out_valid_o && !out_ready_i;
  assign in_acc    = in_valid_i && in_ready_o;
  // A failed request must carry a zero offset.
  assign fail_off  = out_valid_o && (out_data_o.status != ST_OK) &&
                     (out_data_o.payload_offset != '0);

  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o, "output beat dropped")
  `ASSERT_PROP(a_out_stable, clk_i, rst_ni, out_stall |=> $stable(out_data_o), "payload moved")
  `ASSERT_PROP(a_one_at_a_time, clk_i, rst_ni, in_acc |=> !in_ready_o, "second request taken")
  `ASSERT_NEVER(a_fail_zero_offset, clk_i, rst_ni, fail_off, "failed request has an offset")

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (.*);

`default_nettype wire
